FILE: rtl/core/iba_pkg.sv
// Shared widths, codes and helpers of the integral image box average block.
package iba_pkg;

	localparam int MAX_DIM_DEF = 64;

	localparam int CFG_W    = 7;
	localparam int PIX_W    = 8;
	localparam int QPOS_W   = 6;
	localparam int STATUS_W = 2;
	localparam int INTEG_W  = 20;
	localparam int SMOOTH_W = 8;
	localparam int STORE_W  = 21;
	localparam int RSUM_W   = 14;
	localparam int SUM_W    = 24;
	localparam int AREA_W   = 13;
	localparam int NUM_W    = 24;
	localparam int DEN_W    = AREA_W + 1;
	localparam int CIDX_W   = 2;

	localparam logic [CFG_W-1:0] WIN_MAX   = 7'd64;
	localparam logic [CFG_W-1:0] WIN_RESET = 7'd3;

	localparam logic [CIDX_W-1:0] REG_IMAGE_ROWS  = 2'd0;
	localparam logic [CIDX_W-1:0] REG_IMAGE_COLS  = 2'd1;
	localparam logic [CIDX_W-1:0] REG_WINDOW_ROWS = 2'd2;
	localparam logic [CIDX_W-1:0] REG_WINDOW_COLS = 2'd3;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OUTSIDE    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_LOADED = 2'd2;

	typedef enum logic [2:0] {
		RD_BR  = 3'd0,
		RD_TR  = 3'd1,
		RD_BL  = 3'd2,
		RD_TL  = 3'd3,
		RD_CTR = 3'd4
	} rd_sel_t;

	typedef struct packed {
		logic    vld;
		logic    zero;
		rd_sel_t sel;
	} rd_tag_t;

	function automatic logic [CFG_W-1:0] clamp_cfg(input logic [CFG_W-1:0] v,
			input logic [CFG_W-1:0] hi);
		logic [CFG_W-1:0] r;
		r = v;
		if (v == '0) r = CFG_W'(1);
		else if (v > hi) r = hi;
		return r;
	endfunction

endpackage

FILE: rtl/core/iba_if.sv
// Request and response channel interfaces of the integral image box average block.
interface iba_req_if;
	import iba_pkg::*;
	logic              valid;
	logic              ready;
	logic              cmd;
	logic [PIX_W-1:0]  pixel;
	logic [QPOS_W-1:0] query_row;
	logic [QPOS_W-1:0] query_col;

	modport source(output valid, cmd, pixel, query_row, query_col, input ready);
	modport sink(input valid, cmd, pixel, query_row, query_col, output ready);
endinterface

interface iba_rsp_if;
	import iba_pkg::*;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [INTEG_W-1:0]  integral_value;
	logic [SMOOTH_W-1:0] smoothed_value;

	modport source(output valid, status, integral_value, smoothed_value, input ready);
	modport sink(input valid, status, integral_value, smoothed_value, output ready);
endinterface

FILE: rtl/core/iba_mem.sv
// Summed-area table memory: one write port, one registered read port.
module iba_mem import iba_pkg::*; #(
	parameter int ADDR_W = 12
) (
	input  logic               clk,
	input  logic               we,
	input  logic [ADDR_W-1:0]  waddr,
	input  logic [STORE_W-1:0] wdata,
	input  logic               re,
	input  logic [ADDR_W-1:0]  raddr,
	output logic [STORE_W-1:0] rdata
);

	logic [STORE_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re) rdata <= mem[raddr];
	end

endmodule

FILE: rtl/core/iba_div.sv
// Restoring divider, one quotient bit per cycle.
module iba_div import iba_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic [NUM_W-1:0] quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0]   rem_sh;
	logic [DEN_W+1:0] diff;
	logic             ge;

	assign rem_sh = {rem_q, quo_q[NUM_W-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, den_q};
	assign ge     = ~diff[DEN_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= '0;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quot = quo_q;

endmodule

FILE: rtl/core/integral_image_box_average.sv
// Top level: summed-area table build and box-average query engine.
// Load words take pixels in row-major order and build a summed-area table in a
// single-port-read memory; a load is accepted, reads the entry one row up, and
// writes back. A query word is accepted, sets up its window, makes five table
// reads through the one read port, drains, runs the bit-serial divider that
// forms the rounded average, sees it finish, and loads the output register. A
// query with a bad position or before the image is loaded goes from accept
// straight to the output register with its status word. One word is worked on
// at a time; the output register lets the next word be accepted while a result
// waits. The table needs no clearing after reset, so the block is ready right away.
module integral_image_box_average import iba_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	iba_req_if.sink           req,
	iba_rsp_if.source         rsp,
	input  logic              cfg_we,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_wdata
);

	localparam int DW    = $clog2(MAX_DIM);
	localparam int AW    = 2 * DW;
	localparam int CNT_W = (DW + 1 > CFG_W) ? DW + 1 : CFG_W;
	localparam logic [CFG_W-1:0] DIM_HI    = CFG_W'((MAX_DIM < 127) ? MAX_DIM : 127);
	localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'((MAX_DIM < 64) ? MAX_DIM : 64);

	typedef enum logic [7:0] {
		S_IDLE    = 8'b0000_0001,
		S_LD_RD   = 8'b0000_0010,
		S_LD_WR   = 8'b0000_0100,
		S_Q_SETUP = 8'b0000_1000,
		S_Q_RD    = 8'b0001_0000,
		S_Q_TAIL  = 8'b0010_0000,
		S_Q_DIV   = 8'b0100_0000,
		S_DONE    = 8'b1000_0000
	} state_t;

	state_t              state_q;
	logic [CFG_W-1:0]    img_rows_q, img_cols_q, win_rows_q, win_cols_q;
	logic [DW-1:0]       load_row_q, load_col_q;
	logic [RSUM_W-1:0]   rsum_q;
	logic                loaded_q;
	rd_sel_t             rd_k_q;
	rd_tag_t             tag_s1;
	logic                rsp_valid_q;

	logic [PIX_W-1:0]    pix_q;
	logic [QPOS_W-1:0]   qr_q, qc_q;
	logic [CFG_W-1:0]    top_q, left_q, bot_q, rgt_q;
	logic [AREA_W-1:0]   area_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [INTEG_W-1:0]  integ_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [STATUS_W-1:0] status_out_q;
	logic [INTEG_W-1:0]  integ_out_q;
	logic [SMOOTH_W-1:0] smooth_out_q;

	logic                accept;
	logic                out_load;
	logic [STATUS_W-1:0] acc_status;
	logic [CFG_W-1:0]    dr, dc, qr7, qc7, bot_raw, rgt_raw;
	logic [CFG_W-1:0]    top_m1, left_m1;
	logic [2*CFG_W-1:0]  area_full;
	logic                mem_we, mem_re;
	logic [AW-1:0]       mem_waddr, mem_raddr;
	logic [STORE_W-1:0]  mem_wdata, mem_rdata, rd_val;
	logic [DW-1:0]       rrow, rcol;
	rd_tag_t             tag;
	logic [CNT_W-1:0]    col_nx, row_nx;
	logic [SUM_W-2:0]    sum_pos;
	logic [NUM_W-1:0]    div_num;
	logic [DEN_W-1:0]    div_den;
	logic                div_start, div_busy;
	logic [NUM_W-1:0]    div_quot;
	logic [SMOOTH_W-1:0] avg_sat;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign out_load  = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);

	always_comb begin
		acc_status = ST_OK;
		if (({1'b0, req.query_row} >= img_rows_q)
				|| ({1'b0, req.query_col} >= img_cols_q))
			acc_status = ST_OUTSIDE;
		else if (!loaded_q)
			acc_status = ST_NOT_LOADED;
	end

	// window corners, each edge clipped to the image
	assign dr        = {1'b0, win_rows_q[CFG_W-1:1]};
	assign dc        = {1'b0, win_cols_q[CFG_W-1:1]};
	assign qr7       = {1'b0, qr_q};
	assign qc7       = {1'b0, qc_q};
	assign bot_raw   = qr7 + dr;
	assign rgt_raw   = qc7 + dc;
	assign area_full = win_rows_q * win_cols_q;
	assign top_m1    = top_q - CFG_W'(1);
	assign left_m1   = left_q - CFG_W'(1);

	always_comb begin
		mem_re = 1'b0;
		rrow   = load_row_q - DW'(1);
		rcol   = load_col_q;
		tag    = '{vld: 1'b0, zero: 1'b0, sel: rd_k_q};
		case (state_q)
			S_LD_RD: begin
				mem_re   = 1'b1;
				tag.zero = (load_row_q == '0);
			end
			S_Q_RD: begin
				mem_re  = 1'b1;
				tag.vld = 1'b1;
				case (rd_k_q)
					RD_BR: begin
						rrow = DW'(bot_q);
						rcol = DW'(rgt_q);
					end
					RD_TR: begin
						rrow     = DW'(top_m1);
						rcol     = DW'(rgt_q);
						tag.zero = (top_q == '0);
					end
					RD_BL: begin
						rrow     = DW'(bot_q);
						rcol     = DW'(left_m1);
						tag.zero = (left_q == '0);
					end
					RD_TL: begin
						rrow     = DW'(top_m1);
						rcol     = DW'(left_m1);
						tag.zero = (top_q == '0) || (left_q == '0);
					end
					default: begin
						rrow = DW'(qr_q);
						rcol = DW'(qc_q);
					end
				endcase
			end
			default: ;
		endcase
	end

	assign mem_raddr = {rrow, rcol};
	assign rd_val    = tag_s1.zero ? '0 : mem_rdata;
	assign mem_we    = (state_q == S_LD_WR);
	assign mem_waddr = {load_row_q, load_col_q};
	assign mem_wdata = STORE_W'(rsum_q) + rd_val;

	iba_mem #(.ADDR_W(AW)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign col_nx = CNT_W'(load_col_q) + CNT_W'(1);
	assign row_nx = CNT_W'(load_row_q) + CNT_W'(1);

	assign sum_pos   = sum_q[SUM_W-1] ? '0 : sum_q[SUM_W-2:0];
	assign div_num   = NUM_W'({sum_pos, 1'b0}) + NUM_W'(area_q);
	assign div_den   = {area_q, 1'b0};
	assign div_start = (state_q == S_Q_TAIL);
	assign avg_sat   = (|div_quot[NUM_W-1:SMOOTH_W]) ? '1 : div_quot[SMOOTH_W-1:0];

	iba_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			img_rows_q  <= DIM_RESET;
			img_cols_q  <= DIM_RESET;
			win_rows_q  <= WIN_RESET;
			win_cols_q  <= WIN_RESET;
			load_row_q  <= '0;
			load_col_q  <= '0;
			rsum_q      <= '0;
			loaded_q    <= 1'b0;
			rd_k_q      <= RD_BR;
			tag_s1      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			tag_s1 <= tag;
			if (out_load) rsp_valid_q <= 1'b1;
			else if (rsp.ready) rsp_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.cmd == CMD_LOAD) state_q <= S_LD_RD;
						else if (acc_status != ST_OK) state_q <= S_DONE;
						else state_q <= S_Q_SETUP;
					end
				end
				S_LD_RD: begin
					rsum_q  <= (load_col_q == '0) ? RSUM_W'(pix_q)
						: rsum_q + RSUM_W'(pix_q);
					state_q <= S_LD_WR;
				end
				S_LD_WR: begin
					state_q <= S_IDLE;
					if (col_nx >= CNT_W'(img_cols_q)) begin
						load_col_q <= '0;
						if (row_nx >= CNT_W'(img_rows_q)) begin
							load_row_q <= '0;
							loaded_q   <= 1'b1;
						end else begin
							load_row_q <= DW'(row_nx);
						end
					end else begin
						load_col_q <= DW'(col_nx);
					end
				end
				S_Q_SETUP: begin
					rd_k_q  <= RD_BR;
					state_q <= S_Q_RD;
				end
				S_Q_RD: begin
					if (rd_k_q == RD_CTR) state_q <= S_Q_TAIL;
					else rd_k_q <= rd_sel_t'(rd_k_q + 3'd1);
				end
				S_Q_TAIL: state_q <= S_Q_DIV;
				S_Q_DIV: begin
					if (!div_busy) state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (cfg_we) begin
				case (cfg_index)
					REG_IMAGE_ROWS, REG_IMAGE_COLS: begin
						if (cfg_index == REG_IMAGE_ROWS)
							img_rows_q <= clamp_cfg(cfg_wdata, DIM_HI);
						else
							img_cols_q <= clamp_cfg(cfg_wdata, DIM_HI);
						load_row_q <= '0;
						load_col_q <= '0;
						rsum_q     <= '0;
						loaded_q   <= 1'b0;
					end
					REG_WINDOW_ROWS: win_rows_q <= clamp_cfg(cfg_wdata, WIN_MAX);
					REG_WINDOW_COLS: win_cols_q <= clamp_cfg(cfg_wdata, WIN_MAX);
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_q        <= req.pixel;
			qr_q         <= req.query_row;
			qc_q         <= req.query_col;
			res_status_q <= acc_status;
		end
		if (state_q == S_Q_SETUP) begin
			top_q  <= (qr7 > dr) ? qr7 - dr : '0;
			left_q <= (qc7 > dc) ? qc7 - dc : '0;
			bot_q  <= (bot_raw > img_rows_q - CFG_W'(1)) ? img_rows_q - CFG_W'(1)
				: bot_raw;
			rgt_q  <= (rgt_raw > img_cols_q - CFG_W'(1)) ? img_cols_q - CFG_W'(1)
				: rgt_raw;
			area_q <= area_full[AREA_W-1:0];
		end
		if (tag_s1.vld) begin
			case (tag_s1.sel)
				RD_BR:   sum_q <= SUM_W'(rd_val);
				RD_TR:   sum_q <= sum_q - SUM_W'(rd_val);
				RD_BL:   sum_q <= sum_q - SUM_W'(rd_val);
				RD_TL:   sum_q <= sum_q + SUM_W'(rd_val);
				default: integ_q <= rd_val[INTEG_W-1:0];
			endcase
		end
		if (out_load) begin
			status_out_q <= res_status_q;
			integ_out_q  <= (res_status_q == ST_OK) ? integ_q : '0;
			smooth_out_q <= (res_status_q == ST_OK) ? avg_sat : '0;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.status         = status_out_q;
	assign rsp.integral_value = integ_out_q;
	assign rsp.smoothed_value = smooth_out_q;

endmodule

FILE: rtl/core/iba_checker.sv
// Port-level checks of the integral image box average block, bound to the top level.
module iba_checker import iba_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic [STATUS_W-1:0] rsp_status,
	input logic [INTEG_W-1:0]  rsp_integral_value,
	input logic [SMOOTH_W-1:0] rsp_smoothed_value
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response word dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_integral_value)
			&& $stable(rsp_smoothed_value))
		else $error("response word changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != ST_OK) |-> (rsp_integral_value == '0)
			&& (rsp_smoothed_value == '0))
		else $error("error response carries nonzero values");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous word still in work");

endmodule

bind integral_image_box_average iba_checker u_iba_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.req_valid          (req.valid),
	.req_ready          (req.ready),
	.rsp_valid          (rsp.valid),
	.rsp_ready          (rsp.ready),
	.rsp_status         (rsp.status),
	.rsp_integral_value (rsp.integral_value),
	.rsp_smoothed_value (rsp.smoothed_value)
);

FILE: tb/sv/tb_integral_image_box_average.sv
// Testbench of the integral image box average block with a summed-area table predictor.
module tb_integral_image_box_average;
	timeunit 1ns;
	timeprecision 1ps;
	import iba_pkg::*;

	localparam int DIM         = MAX_DIM_DEF;
	localparam int SETTLE      = 40;
	localparam int LONG_HOLD   = 300;
	localparam int WORD_TARGET = 625;
	localparam int LIMIT_NS    = 1_000_000;
	localparam int MAX_REPORTS = 200;

	typedef struct packed {
		logic              cmd;
		logic [PIX_W-1:0]  pixel;
		logic [QPOS_W-1:0] row;
		logic [QPOS_W-1:0] col;
	} word_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [INTEG_W-1:0]  integral;
		logic [SMOOTH_W-1:0] smoothed;
	} answer_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [CIDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]  cfg_wdata;

	iba_req_if req_ch();
	iba_rsp_if rsp_ch();

	integral_image_box_average uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	logic [STORE_W-1:0] sat_mem [DIM*DIM];
	logic [RSUM_W-1:0]  row_sum = '0;
	int                 ld_row = 0;
	int                 ld_col = 0;
	bit                 img_loaded = 1'b0;
	int                 img_rows = DIM;
	int                 img_cols = DIM;
	int                 win_rows = int'(WIN_RESET);
	int                 win_cols = int'(WIN_RESET);

	word_t   pending_words[$];
	answer_t query_answers[$];
	word_t   cur_word;
	bit      offering = 1'b0;
	int      send_wait = 0;
	int      send_gap_max = 0;
	int      recv_wait = 0;
	int      recv_gap_max = 0;
	int      hold_asked = 0;
	int      hold_seen = 0;
	int      hold_left = 0;
	int      fail_count = 0;
	int      words_pushed = 0;

	function automatic int sat_at(int r, int c);
		if (r < 0 || c < 0) return 0;
		return int'(sat_mem[r*DIM + c]);
	endfunction

	function automatic int clamp_to(int v, int hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	task automatic sat_step(input word_t w);
		int      above, qr, qc, dr, dc, top, left, bot, rgt, area;
		longint  sum, avg;
		answer_t ans;
		if (w.cmd == CMD_LOAD) begin
			if (ld_col == 0) row_sum = RSUM_W'(w.pixel);
			else row_sum = row_sum + RSUM_W'(w.pixel);
			above = (ld_row > 0) ? sat_at(ld_row - 1, ld_col) : 0;
			sat_mem[ld_row*DIM + ld_col] = STORE_W'(int'(row_sum) + above);
			ld_col++;
			if (ld_col >= img_cols) begin
				ld_col = 0;
				ld_row++;
				if (ld_row >= img_rows) begin
					ld_row = 0;
					img_loaded = 1'b1;
				end
			end
		end else begin
			qr = w.row;
			qc = w.col;
			ans = '0;
			if (qr >= img_rows || qc >= img_cols) begin
				ans.status = ST_OUTSIDE;
			end else if (!img_loaded) begin
				ans.status = ST_NOT_LOADED;
			end else begin
				dr = win_rows / 2;
				dc = win_cols / 2;
				top = (qr > dr) ? qr - dr : 0;
				left = (qc > dc) ? qc - dc : 0;
				bot = (qr + dr > img_rows - 1) ? img_rows - 1 : qr + dr;
				rgt = (qc + dc > img_cols - 1) ? img_cols - 1 : qc + dc;
				sum = longint'(sat_at(bot, rgt)) - sat_at(top - 1, rgt)
					- sat_at(bot, left - 1) + sat_at(top - 1, left - 1);
				if (sum < 0) sum = 0;
				area = win_rows * win_cols;
				avg = (2 * sum + area) / (2 * area);
				if (avg > 255) avg = 255;
				ans.status = ST_OK;
				ans.integral = INTEG_W'(sat_at(qr, qc));
				ans.smoothed = SMOOTH_W'(avg);
			end
			query_answers.push_back(ans);
		end
	endtask

	task automatic apply_reg(input logic [CIDX_W-1:0] idx, input int val);
		case (idx)
			REG_IMAGE_ROWS, REG_IMAGE_COLS: begin
				if (idx == REG_IMAGE_ROWS) img_rows = clamp_to(val, DIM);
				else img_cols = clamp_to(val, DIM);
				ld_row = 0;
				ld_col = 0;
				row_sum = '0;
				img_loaded = 1'b0;
			end
			REG_WINDOW_ROWS: win_rows = clamp_to(val, int'(WIN_MAX));
			REG_WINDOW_COLS: win_cols = clamp_to(val, int'(WIN_MAX));
			default: ;
		endcase
	endtask

	task automatic write_reg(input logic [CIDX_W-1:0] idx, input int val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= CFG_W'(val);
		apply_reg(idx, val);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic push_word(input logic cmd, input int pix, input int r, input int c);
		word_t w;
		w.cmd = cmd;
		w.pixel = PIX_W'(pix);
		w.row = QPOS_W'(r);
		w.col = QPOS_W'(c);
		pending_words.push_back(w);
		words_pushed++;
	endtask

	task automatic wait_idle();
		while (pending_words.size() != 0 || offering || query_answers.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic load_image(input int pix_mode);
		int n, pix;
		for (n = 0; n < img_rows * img_cols; n++) begin
			case (pix_mode)
				1: pix = 255;
				2: pix = 255 * $urandom_range(0, 1);
				default: pix = $urandom_range(0, 255);
			endcase
			push_word(CMD_LOAD, pix, 0, 0);
		end
	endtask

	task automatic push_queries(input int count, input int load_pct);
		int n, r, c;
		for (n = 0; n < count; n++) begin
			r = ($urandom_range(0, 99) < 80) ? $urandom_range(0, img_rows - 1)
				: $urandom_range(0, 63);
			c = ($urandom_range(0, 99) < 80) ? $urandom_range(0, img_cols - 1)
				: $urandom_range(0, 63);
			push_word(CMD_QUERY, 0, r, c);
			if ($urandom_range(0, 99) < load_pct)
				repeat ($urandom_range(1, 4)) push_word(CMD_LOAD, $urandom_range(0, 255), 0, 0);
		end
	endtask

	function automatic int pick_dim(input int limit);
		int pick;
		pick = $urandom_range(0, 99);
		if (limit >= DIM && pick < 12) return DIM;
		if (pick < 25) return 1;
		return $urandom_range(1, (limit < 8) ? limit : 8);
	endfunction

	// out-of-range codes that clamp to the same size
	function automatic int dim_code(input int d);
		if (d == DIM && $urandom_range(0, 4) == 0) return $urandom_range(DIM + 1, 127);
		if (d == 1 && $urandom_range(0, 4) == 0) return 0;
		return d;
	endfunction

	function automatic int pick_window();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 10) return 64;
		if (pick < 15) return 0;
		if (pick < 20) return $urandom_range(65, 127);
		if (pick < 35) return 2 * $urandom_range(1, 3);
		return $urandom_range(1, 9);
	endfunction

	function automatic int pick_gap();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 3;
			default: return 11;
		endcase
	endfunction

	task automatic compare_field(input string label, input logic [INTEG_W-1:0] want,
			input logic [INTEG_W-1:0] got);
		if (got !== want) begin
			fail_count++;
			// limit log size
			if (fail_count <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
		end
	endtask

	task automatic check_answer();
		answer_t want;
		if (query_answers.size() == 0) begin
			fail_count++;
			if (fail_count <= MAX_REPORTS)
				$display("%0t: result with no query waiting, expected none, actual %0d/%0d/%0d",
					$time, rsp_ch.status, rsp_ch.integral_value,
					rsp_ch.smoothed_value);
		end else begin
			want = query_answers.pop_front();
			compare_field("status", INTEG_W'(want.status), INTEG_W'(rsp_ch.status));
			compare_field("integral_value", want.integral, rsp_ch.integral_value);
			compare_field("smoothed_value", INTEG_W'(want.smoothed),
				INTEG_W'(rsp_ch.smoothed_value));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				sat_step(cur_word);
				offering = 1'b0;
			end
			if (!offering) begin
				if (send_wait > 0) begin
					send_wait--;
				end else if (pending_words.size() != 0) begin
					cur_word = pending_words.pop_front();
					offering = 1'b1;
					send_wait = $urandom_range(0, send_gap_max);
					req_ch.cmd <= cur_word.cmd;
					req_ch.pixel <= cur_word.pixel;
					req_ch.query_row <= cur_word.row;
					req_ch.query_col <= cur_word.col;
				end
			end
			req_ch.valid <= offering;
		end else begin
			req_ch.valid <= 1'b0;
			req_ch.cmd <= CMD_LOAD;
			req_ch.pixel <= '0;
			req_ch.query_row <= '0;
			req_ch.query_col <= '0;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				check_answer();
				recv_wait = $urandom_range(0, recv_gap_max);
			end else if (recv_wait > 0) begin
				recv_wait--;
			end
			if (hold_seen != hold_asked) begin
				hold_seen = hold_asked;
				hold_left = LONG_HOLD;
			end else if (hold_left > 0) begin
				hold_left--;
			end
			rsp_ch.ready <= (recv_wait == 0 && hold_left == 0);
		end else begin
			rsp_ch.ready <= 1'b0;
		end
	end

	initial begin
		#(LIMIT_NS);
		$display("tb_integral_image_box_average NOT OK");
		$finish;
	end

	initial begin
		int phase, kind, rows, cols, pix_mode;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		push_word(CMD_QUERY, 0, 0, 0);
		push_word(CMD_QUERY, 0, 63, 63);
		push_word(CMD_LOAD, 255, 0, 0);
		wait_idle();
		write_reg(REG_IMAGE_ROWS, 3);
		write_reg(REG_IMAGE_COLS, 3);
		write_reg(REG_WINDOW_ROWS, 2);
		write_reg(REG_WINDOW_COLS, 2);
		push_word(CMD_QUERY, 0, 3, 1);
		push_word(CMD_QUERY, 0, 1, 3);
		load_image(1);
		push_word(CMD_QUERY, 0, 1, 1);
		push_word(CMD_QUERY, 0, 2, 2);
		push_word(CMD_QUERY, 0, 0, 0);
		push_word(CMD_QUERY, 0, 2, 0);
		push_word(CMD_QUERY, 0, 63, 0);
		wait_idle();
		write_reg(REG_WINDOW_ROWS, 1);
		write_reg(REG_WINDOW_COLS, 0);
		push_word(CMD_LOAD, 0, 0, 0);
		push_word(CMD_LOAD, 0, 0, 0);
		push_word(CMD_QUERY, 0, 0, 0);
		push_word(CMD_QUERY, 0, 0, 2);

		phase = 0;
		while (words_pushed < WORD_TARGET) begin
			wait_idle();
			send_gap_max = (phase == 0) ? 0 : pick_gap();
			recv_gap_max = pick_gap();
			kind = (phase == 0) ? 0 : $urandom_range(0, 99);
			if (kind < 65) begin
				if (phase == 0) begin
					rows = $urandom_range(2, 4);
					cols = $urandom_range(2, 4);
				end else begin
					rows = pick_dim(DIM);
					cols = pick_dim(rows > 8 ? 2 : (rows <= 2 ? DIM : 8));
				end
				write_reg(REG_IMAGE_ROWS, dim_code(rows));
				write_reg(REG_IMAGE_COLS, dim_code(cols));
				if ($urandom_range(0, 1) == 1) begin
					write_reg(REG_WINDOW_ROWS, pick_window());
					write_reg(REG_WINDOW_COLS, pick_window());
				end
				push_queries($urandom_range(0, 2), 0);
				pix_mode = $urandom_range(0, 9);
				load_image((pix_mode < 2) ? pix_mode + 1 : 0);
				if (phase == 0) begin
					// stall the result side so the input backs up
					hold_asked++;
					push_queries(20, 0);
				end else begin
					push_queries($urandom_range(6, 16), 20);
				end
			end else if (kind < 85) begin
				if ($urandom_range(0, 2) != 0) write_reg(REG_WINDOW_ROWS, pick_window());
				if ($urandom_range(0, 2) != 0) write_reg(REG_WINDOW_COLS, pick_window());
				push_queries($urandom_range(4, 12), 10);
			end else begin
				repeat ($urandom_range(10, 30))
					push_word(1'($urandom_range(0, 1)), $urandom_range(0, 255),
						$urandom_range(0, 63), $urandom_range(0, 63));
			end
			phase++;
		end

		wait_idle();
		if (fail_count == 0)
			$display("tb_integral_image_box_average OK");
		else
			$display("tb_integral_image_box_average NOT OK");
		$finish;
	end

endmodule
